/* sv/gha_pkg.sv */
package gha_pkg;

  // Table geometry and field widths
  localparam int CAPACITY = 1024;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int GEN_W    = 16;
  localparam int CNT_W    = SLOT_W + 1;
  localparam int OP_W     = 2;
  localparam int HANDLE_W = SLOT_W + GEN_W;
  localparam int IN_W     = 32;
  localparam int OUT_W    = 32;

  localparam logic [CNT_W-1:0] SLOT_LIMIT_RESET = CNT_W'(CAPACITY);

  typedef enum logic [OP_W-1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_CHECK   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_STALE = 2'd2
  } status_t;

  // Per-slot record: alive flag and current generation
  typedef struct packed {
    logic             alive;
    logic [GEN_W-1:0] gen;
  } slot_entry_t;

  // Free stack record: freed slot and the generation it will be handed out with
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [GEN_W-1:0]  gen;
  } stack_entry_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    slot_entry_t       data;
  } slot_wr_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    stack_entry_t      data;
  } stack_wr_t;

  // Request payload, last field in the low bits
  typedef struct packed {
    logic [GEN_W-1:0]  handle_generation;
    logic [SLOT_W-1:0] handle_slot;
    op_t               opcode;
  } in_item_t;

  // Result payload, last field in the low bits
  typedef struct packed {
    logic              is_live;
    logic [GEN_W-1:0]  new_generation;
    logic [SLOT_W-1:0] new_slot;
    status_t           status;
  } out_item_t;

endpackage

/* sv/gha_slot_table.sv */
module gha_slot_table (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rd_en,
  input  logic [gha_pkg::SLOT_W-1:0] rd_addr,
  input  gha_pkg::slot_wr_t     wr,
  output gha_pkg::slot_entry_t  rd_data
);

  gha_pkg::slot_entry_t mem [gha_pkg::CAPACITY];
  gha_pkg::slot_entry_t rd_q_r;
  gha_pkg::slot_entry_t byp_data_r;
  logic                 byp_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_q_r     <= mem[rd_addr];
      byp_data_r <= wr.data;
    end
  end

  // Remember a same-address write so the read sees the new record
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else if (rd_en) begin
      byp_r <= wr.en && (wr.addr == rd_addr);
    end
  end

  assign rd_data = byp_r ? byp_data_r : rd_q_r;

endmodule

/* sv/gha_free_stack.sv */
module gha_free_stack (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rd_en,
  input  logic [gha_pkg::SLOT_W-1:0] rd_addr,
  input  gha_pkg::stack_wr_t    wr,
  output gha_pkg::stack_entry_t rd_data
);

  gha_pkg::stack_entry_t mem [gha_pkg::CAPACITY];
  gha_pkg::stack_entry_t rd_q_r;
  gha_pkg::stack_entry_t byp_data_r;
  logic                  byp_r;

  // Push port and registered top-of-stack read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_q_r     <= mem[rd_addr];
      byp_data_r <= wr.data;
    end
  end

  // Forward a push that lands on the entry being read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else if (rd_en) begin
      byp_r <= wr.en && (wr.addr == rd_addr);
    end
  end

  assign rd_data = byp_r ? byp_data_r : rd_q_r;

endmodule

/* sv/generational_handle_allocator.sv */
// Channel | Direction | Handshake               | Payload
// in_     | request   | in_tvalid / in_tready   | in_tuser[1:0], in_tdata[31:0]
// out_    | result    | out_tvalid / out_tready | out_tdata[31:0]
// cfg_    | register  | cfg_wr_en               | cfg_wr_data[10:0] (slot_limit)
//
// One request per cycle sustained while results drain; an accepted request loads
// the input register together with the slot table and free stack reads, then the
// result register, from which the result leaves.
// Reset is synchronous and needs no clearing pass, since the slot table is only
// consulted below the fresh-slot count and the free stack only below its fill
// count. A stalled result register holds the input stage, which then stops
// taking requests.
module generational_handle_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] opcode
  input  logic [gha_pkg::OP_W-1:0]  in_tuser,
  // [9:0] handle_slot, [25:10] handle_generation, [31:26] zero
  input  logic [gha_pkg::IN_W-1:0]  in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] status, [11:2] new_slot, [27:12] new_generation, [28] is_live,
  // [31:29] zero
  output logic [gha_pkg::OUT_W-1:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [gha_pkg::CNT_W-1:0] cfg_wr_data
);

  logic                         s1_valid_r;
  gha_pkg::in_item_t            s1_item_r;
  logic                         out_valid_r;
  gha_pkg::out_item_t           out_item_r;
  logic [gha_pkg::CNT_W-1:0]    limit_r;
  logic [gha_pkg::CNT_W-1:0]    fc_r;
  logic [gha_pkg::CNT_W-1:0]    fresh_r;

  logic                         accept;
  logic                         s1_fire;
  gha_pkg::in_item_t            in_item;
  gha_pkg::slot_entry_t         slot_rd;
  gha_pkg::stack_entry_t        stk_rd;
  gha_pkg::slot_wr_t            slot_wr;
  gha_pkg::stack_wr_t           stack_wr;
  gha_pkg::out_item_t           res;
  logic [gha_pkg::CNT_W-1:0]    usable;
  logic                         live;
  logic [gha_pkg::GEN_W-1:0]    gen_inc;
  logic [gha_pkg::CNT_W-1:0]    fc_calc;
  logic [gha_pkg::CNT_W-1:0]    fresh_calc;
  logic [gha_pkg::CNT_W-1:0]    fc_nxt;
  logic [gha_pkg::SLOT_W-1:0]   top_addr;

  assign in_item = gha_pkg::in_item_t'({in_tdata[gha_pkg::HANDLE_W-1:0], in_tuser});

  // Handshake: stage advances when the result register is free or draining
  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // Effective slot count
  assign usable = (limit_r > gha_pkg::CNT_W'(gha_pkg::CAPACITY)) ?
                  gha_pkg::CNT_W'(gha_pkg::CAPACITY) : limit_r;

  // Live test on the slot record read for this request
  assign live = ({1'b0, s1_item_r.handle_slot} < usable) &&
                ({1'b0, s1_item_r.handle_slot} < fresh_r) &&
                slot_rd.alive &&
                (slot_rd.gen == s1_item_r.handle_generation);

  assign gen_inc = slot_rd.gen + gha_pkg::GEN_W'(1);

  // Decode the request and form result and table updates
  always_comb begin
    res        = '0;
    fc_calc    = fc_r;
    fresh_calc = fresh_r;
    slot_wr    = '0;
    stack_wr   = '0;
    unique case (s1_item_r.opcode)
      gha_pkg::OP_CREATE: begin
        if (fc_r != '0) begin
          res.new_slot       = stk_rd.slot;
          res.new_generation = stk_rd.gen;
          fc_calc            = fc_r - gha_pkg::CNT_W'(1);
          slot_wr.en         = 1'b1;
          slot_wr.addr       = stk_rd.slot;
          slot_wr.data       = '{alive: 1'b1, gen: stk_rd.gen};
        end else if (fresh_r < usable) begin
          res.new_slot = fresh_r[gha_pkg::SLOT_W-1:0];
          fresh_calc   = fresh_r + gha_pkg::CNT_W'(1);
          slot_wr.en   = 1'b1;
          slot_wr.addr = fresh_r[gha_pkg::SLOT_W-1:0];
          slot_wr.data = '{alive: 1'b1, gen: '0};
        end else begin
          res.status = gha_pkg::ST_FULL;
        end
      end
      gha_pkg::OP_DESTROY: begin
        if (live) begin
          res.is_live  = 1'b1;
          slot_wr.en   = 1'b1;
          slot_wr.addr = s1_item_r.handle_slot;
          slot_wr.data = '{alive: 1'b0, gen: gen_inc};
          if (fc_r < gha_pkg::CNT_W'(gha_pkg::CAPACITY)) begin
            stack_wr.en   = 1'b1;
            stack_wr.addr = fc_r[gha_pkg::SLOT_W-1:0];
            stack_wr.data = '{slot: s1_item_r.handle_slot, gen: gen_inc};
            fc_calc       = fc_r + gha_pkg::CNT_W'(1);
          end
        end else begin
          res.status = gha_pkg::ST_STALE;
        end
      end
      gha_pkg::OP_CHECK: begin
        if (live) begin
          res.is_live = 1'b1;
        end else begin
          res.status = gha_pkg::ST_STALE;
        end
      end
      default: begin
        res = '0;
      end
    endcase
    slot_wr.en  = slot_wr.en && s1_fire;
    stack_wr.en = stack_wr.en && s1_fire;
  end

  // Next request reads the stack top as left by the current one
  assign fc_nxt   = s1_fire ? fc_calc : fc_r;
  assign top_addr = fc_nxt[gha_pkg::SLOT_W-1:0] - gha_pkg::SLOT_W'(1);

  gha_slot_table u_slot_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (in_item.handle_slot),
    .wr      (slot_wr),
    .rd_data (slot_rd)
  );

  gha_free_stack u_free_stack (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (top_addr),
    .wr      (stack_wr),
    .rd_data (stk_rd)
  );

  // Control state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fc_r        <= '0;
      fresh_r     <= '0;
      limit_r     <= gha_pkg::SLOT_LIMIT_RESET;
    end else begin
      s1_valid_r  <= accept || (s1_valid_r && !s1_fire);
      out_valid_r <= s1_fire || (out_valid_r && !out_tready);
      fc_r        <= fc_nxt;
      if (s1_fire) begin
        fresh_r <= fresh_calc;
      end
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_item;
    end
    if (s1_fire) begin
      out_item_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(gha_pkg::OUT_W - $bits(gha_pkg::out_item_t)){1'b0}}, out_item_r};

endmodule
